/* rtl/core/chs_pkg.sv */
// ----------------------------------------------------------------------------
// chs_pkg: shared types and constants of the chained hash set
// Field widths, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package chs_pkg;

  localparam int VALUE_W  = 31;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 11;
  localparam int CFG_W    = 7;

  localparam int DEF_NUM_BUCKETS = 64;
  localparam int DEF_NODE_POOL   = 1024;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_DUP    = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_HEAD,
    S_HLOAD,
    S_WALK,
    S_NODE,
    S_ACT,
    S_FREE,
    S_REM1,
    S_REM2,
    S_FIN
  } state_e;

endpackage

`default_nettype wire

/* rtl/core/chained_hash_set.sv */
// ----------------------------------------------------------------------------
// chained_hash_set: hash set with separate chaining
// Insert, search and remove of 31-bit values in a node pool with a free list.
// ----------------------------------------------------------------------------
// One item at a time. An item passes through the following steps:
// - The item is accepted in the idle state.
// - The bit-serial remainder unit runs 31 steps and then signals done.
// - The bucket entry is read from the bucket memory (S_HEAD, S_HLOAD).
// - Each chain node is visited through the node memory read port (S_WALK, S_NODE).
//   A miss sees the end of the chain in a final S_WALK state.
// - State is updated in S_ACT, then in S_FREE or in S_REM1 and S_REM2 where needed.
// - The result is handed on in S_FIN, which waits while an earlier result is still held.
// After reset a clearing pass empties every entry of the bucket memory.
// No item is taken during the clearing pass.
// The result waits in an output register, so the next item may be accepted
// before the result is taken.
`default_nettype none

module chained_hash_set
  import chs_pkg::*;
#(
  parameter int NUM_BUCKETS = DEF_NUM_BUCKETS,
  parameter int NODE_POOL   = DEF_NODE_POOL
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CFG_W-1:0]   cfg_wdata_i,    // bucket_count
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [31:0]        s_axis_tdata,   // value[30:0]
  input  wire logic [OP_W-1:0]    s_axis_tuser,   // op[1:0]
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [23:0]             m_axis_tdata,   // element_count[10:0], bucket_length[21:11]
  output logic [STATUS_W-1:0]     m_axis_tuser    // status[1:0]
);

  localparam int PTR_W  = $clog2(NODE_POOL + 1);
  localparam int IDX_W  = $clog2(NODE_POOL);
  localparam int BIDX_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int MAX_M  = (NUM_BUCKETS < 127) ? NUM_BUCKETS : 127;
  localparam logic [PTR_W-1:0]  NIL      = PTR_W'(NODE_POOL);
  localparam logic [BIDX_W-1:0] BKT_LAST = BIDX_W'(NUM_BUCKETS - 1);
  localparam logic [CFG_W-1:0]  M_MAX    = CFG_W'(MAX_M);

  // memories
  logic [2*PTR_W-1:0] bkt_mem [NUM_BUCKETS];   // {length, head}
  logic [VALUE_W-1:0] nval_mem [NODE_POOL];
  logic [PTR_W-1:0]   nlink_mem [NODE_POOL];

  logic               bkt_we;
  logic [BIDX_W-1:0]  bkt_waddr;
  logic [2*PTR_W-1:0] bkt_wdata;
  logic [2*PTR_W-1:0] bkt_rd_q;
  logic               nval_we;
  logic               nlink_we;
  logic [IDX_W-1:0]   nval_waddr, nlink_waddr, n_raddr;
  logic [VALUE_W-1:0] nval_wdata;
  logic [PTR_W-1:0]   nlink_wdata;
  logic [VALUE_W-1:0] nval_rd_q;
  logic [PTR_W-1:0]   nlink_rd_q;

  state_e             state_q, state_d;
  logic [CFG_W-1:0]   bc_q;
  logic [CFG_W-1:0]   modulus;
  op_e                op_q, op_d;
  logic [VALUE_W-1:0] val_q, val_d;
  logic [BIDX_W-1:0]  bidx_q, bidx_d;
  logic [BIDX_W-1:0]  clr_q, clr_d;
  logic [PTR_W-1:0]   head_q, head_d;
  logic [PTR_W-1:0]   len_q, len_d;
  logic [PTR_W-1:0]   cur_q, cur_d;
  logic [PTR_W-1:0]   prev_q, prev_d;
  logic [PTR_W-1:0]   steps_q, steps_d;
  logic               found_q, found_d;
  logic [PTR_W-1:0]   hlink_q, hlink_d;
  logic [PTR_W-1:0]   free_q, free_d;
  logic [PTR_W-1:0]   mark_q, mark_d;
  logic [PTR_W-1:0]   total_q, total_d;
  logic [PTR_W-1:0]   newlen_q, newlen_d;
  status_e            status_q, status_d;
  logic [PTR_W-1:0]   alloc;
  logic               alloc_go;
  logic [PTR_W-1:0]   len_dec;

  logic               out_valid_q;
  logic [CNT_W-1:0]   out_cnt_q, out_len_q;
  status_e            out_status_q;
  logic               out_load;

  logic               mod_start, mod_done;
  logic [CFG_W-1:0]   mod_rem;
  logic               in_acc;

  assign modulus = (bc_q == '0) ? CFG_W'(1) : ((bc_q > M_MAX) ? M_MAX : bc_q);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign mod_start = in_acc;
  assign len_dec = (len_q != '0) ? len_q - 1'b1 : len_q;

  chs_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (s_axis_tdata[VALUE_W-1:0]),
    .divisor_i  (modulus),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    val_d      = val_q;
    bidx_d     = bidx_q;
    clr_d      = clr_q;
    head_d     = head_q;
    len_d      = len_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    steps_d    = steps_q;
    found_d    = found_q;
    hlink_d    = hlink_q;
    free_d     = free_q;
    mark_d     = mark_q;
    total_d    = total_q;
    newlen_d   = newlen_q;
    status_d   = status_q;
    bkt_we     = 1'b0;
    bkt_waddr  = bidx_q;
    bkt_wdata  = '0;
    nval_we    = 1'b0;
    nlink_we   = 1'b0;
    nval_waddr = alloc[IDX_W-1:0];
    nlink_waddr = alloc[IDX_W-1:0];
    nval_wdata = val_q;
    nlink_wdata = head_q;
    n_raddr    = cur_q[IDX_W-1:0];
    out_load   = 1'b0;
    alloc      = mark_q;
    alloc_go   = 1'b0;

    case (state_q)
      S_CLEAR: begin
        bkt_we    = 1'b1;
        bkt_waddr = clr_q;
        bkt_wdata = {{PTR_W{1'b0}}, NIL};
        clr_d     = clr_q + 1'b1;
        if (clr_q == BKT_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          op_d    = op_e'(s_axis_tuser);
          val_d   = s_axis_tdata[VALUE_W-1:0];
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          bidx_d  = BIDX_W'(mod_rem);
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        state_d = S_HLOAD;
      end
      S_HLOAD: begin
        head_d  = bkt_rd_q[PTR_W-1:0];
        len_d   = bkt_rd_q[2*PTR_W-1:PTR_W];
        cur_d   = bkt_rd_q[PTR_W-1:0];
        prev_d  = NIL;
        steps_d = '0;
        found_d = 1'b0;
        state_d = S_WALK;
      end
      S_WALK: begin
        if (cur_q >= NIL || steps_q == NIL) begin
          state_d = S_ACT;
        end else begin
          state_d = S_NODE;
        end
      end
      S_NODE: begin
        if (nval_rd_q == val_q) begin
          found_d = 1'b1;
          hlink_d = nlink_rd_q;
          state_d = S_ACT;
        end else begin
          prev_d  = cur_q;
          cur_d   = nlink_rd_q;
          steps_d = steps_q + 1'b1;
          state_d = S_WALK;
        end
      end
      S_ACT: begin
        newlen_d = len_q;
        state_d  = S_FIN;
        case (op_q)
          OP_INSERT: begin
            if (found_q) begin
              status_d = ST_DUP;
            end else if (free_q < NIL) begin
              n_raddr = free_q[IDX_W-1:0];
              state_d = S_FREE;
            end else if (mark_q < NIL) begin
              alloc    = mark_q;
              alloc_go = 1'b1;
              mark_d   = mark_q + 1'b1;
            end else begin
              status_d = ST_FULL;
            end
          end
          OP_SEARCH: status_d = found_q ? ST_OK : ST_ABSENT;
          OP_REMOVE: begin
            if (found_q) begin
              state_d = S_REM1;
            end else begin
              status_d = ST_ABSENT;
            end
          end
          default: status_d = ST_ABSENT;
        endcase
      end
      S_FREE: begin
        alloc    = free_q;
        alloc_go = 1'b1;
        free_d   = nlink_rd_q;
        state_d  = S_FIN;
      end
      S_REM1: begin
        nlink_we    = 1'b1;
        nlink_waddr = cur_q[IDX_W-1:0];
        nlink_wdata = free_q;
        free_d      = cur_q;
        bkt_we      = 1'b1;
        bkt_wdata   = {len_dec, (prev_q < NIL) ? head_q : hlink_q};
        newlen_d    = len_dec;
        total_d     = (total_q != '0) ? total_q - 1'b1 : total_q;
        status_d    = ST_OK;
        state_d     = (prev_q < NIL) ? S_REM2 : S_FIN;
      end
      S_REM2: begin
        nlink_we    = 1'b1;
        nlink_waddr = prev_q[IDX_W-1:0];
        nlink_wdata = hlink_q;
        state_d     = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // new node linked at the chain head
    if (alloc_go) begin
      nval_we     = 1'b1;
      nval_waddr  = alloc[IDX_W-1:0];
      nlink_we    = 1'b1;
      nlink_waddr = alloc[IDX_W-1:0];
      nlink_wdata = head_q;
      bkt_we      = 1'b1;
      bkt_wdata   = {len_q + 1'b1, alloc};
      newlen_d    = len_q + 1'b1;
      total_d     = total_q + 1'b1;
      status_d    = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      bc_q        <= CFG_RESET;
      clr_q       <= '0;
      free_q      <= NIL;
      mark_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      free_q  <= free_d;
      mark_q  <= mark_d;
      total_q <= total_d;
      if (cfg_we_i) begin
        bc_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    val_q    <= val_d;
    bidx_q   <= bidx_d;
    head_q   <= head_d;
    len_q    <= len_d;
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    steps_q  <= steps_d;
    found_q  <= found_d;
    hlink_q  <= hlink_d;
    newlen_q <= newlen_d;
    status_q <= status_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_cnt_q    <= CNT_W'(total_q);
      out_len_q    <= CNT_W'(newlen_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (bkt_we) begin
      bkt_mem[bkt_waddr] <= bkt_wdata;
    end
    bkt_rd_q <= bkt_mem[bidx_q];
  end

  always_ff @(posedge clk_i) begin
    if (nval_we) begin
      nval_mem[nval_waddr] <= nval_wdata;
    end
    if (nlink_we) begin
      nlink_mem[nlink_waddr] <= nlink_wdata;
    end
    nval_rd_q  <= nval_mem[n_raddr];
    nlink_rd_q <= nlink_mem[n_raddr];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {2'b00, out_len_q, out_cnt_q};

  // every stored value holds a node taken from the unused tail
  a_total_le_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= mark_q)
    else $error("element count exceeds nodes handed out");

  a_free_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_q == NIL) || (free_q < mark_q))
    else $error("free list head points outside used nodes");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_MOD))
    else $error("accepted item did not start the remainder unit");

  a_fin_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && !out_valid_q) |=> out_valid_q)
    else $error("finished item not presented");

endmodule

`default_nettype wire

/* rtl/core/chs_mod_unit.sv */
// ----------------------------------------------------------------------------
// chs_mod_unit: bit-serial remainder unit
// Restoring shift-subtract, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module chs_mod_unit
  import chs_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [VALUE_W-1:0] dividend_i,
  input  wire logic [CFG_W-1:0]   divisor_i,
  output logic                    done_o,
  output logic [CFG_W-1:0]        rem_o
);

  localparam int CNT_BITS = $clog2(VALUE_W);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(VALUE_W - 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [VALUE_W-1:0]  dvd_q, dvd_d;
  logic [CFG_W-1:0]    dsr_q, dsr_d;
  logic [CFG_W-1:0]    rem_q, rem_d;
  logic [CFG_W:0]      trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[VALUE_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // remainder stays below the divisor, so one subtract per bit suffices
      if (trial >= {1'b0, dsr_q}) begin
        trial = trial - {1'b0, dsr_q};
      end
      rem_d = trial[CFG_W-1:0];
      dvd_d = {dvd_q[VALUE_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb: regression bench for chained_hash_set
// Drives insert, search, remove and no-op items under several bucket counts and
// checks every result against a local model of the chained table. The run
// fills the node pool, exercises the free list and stalls the output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import chs_pkg::*;

  localparam int NB  = DEF_NUM_BUCKETS;
  localparam int NP  = DEF_NODE_POOL;
  localparam int NIL = DEF_NODE_POOL;

  typedef struct packed {
    status_e          status;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] length;
  } hash_result_t;

  class hash_set_scoreboard;
    logic [CNT_W-1:0]   head_q[NB];
    logic [CNT_W-1:0]   len_q[NB];
    logic [VALUE_W-1:0] val_q[NP];
    logic [CNT_W-1:0]   link_q[NP];
    logic [CNT_W-1:0]   free_hd, fresh_mark, total;
    logic [CFG_W-1:0]   buckets;
    hash_result_t       awaited_q[$];
    int                 mismatches;
    int                 checked;
    int                 status_seen[4];

    function new();
      for (int i = 0; i < NB; i++) begin
        head_q[i] = NIL;
        len_q[i]  = '0;
      end
      for (int i = 0; i < NP; i++) begin
        val_q[i]  = '0;
        link_q[i] = NIL;
      end
      free_hd    = NIL;
      fresh_mark = '0;
      total      = '0;
      buckets    = CFG_RESET;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_buckets(logic [CFG_W-1:0] n);
      buckets = n;
    endfunction

    // work out the result of one accepted item and queue it
    function void note_item(op_e op, logic [VALUE_W-1:0] v);
      int m, b, cur, p, hit, prev, steps, n;
      hash_result_t r;
      m = (buckets == 0) ? 1 : ((buckets > NB) ? NB : int'(buckets));
      b = int'(v % m);
      cur = head_q[b];
      p = NIL;
      hit = NIL;
      prev = NIL;
      steps = 0;
      while (cur < NIL && steps < NP) begin
        if (val_q[cur] == v) begin
          hit = cur;
          prev = p;
          break;
        end
        p = cur;
        cur = link_q[cur];
        steps++;
      end
      r.status = ST_ABSENT;
      case (op)
        OP_INSERT: begin
          if (hit < NIL) r.status = ST_DUP;
          else begin
            n = NIL;
            if (free_hd < NIL) begin
              n = free_hd;
              free_hd = link_q[n];
            end else if (fresh_mark < NP) begin
              n = fresh_mark;
              fresh_mark++;
            end
            if (n < NIL) begin
              val_q[n]  = v;
              link_q[n] = head_q[b];
              head_q[b] = n;
              len_q[b]++;
              total++;
              r.status = ST_OK;
            end else r.status = ST_FULL;
          end
        end
        OP_SEARCH: r.status = (hit < NIL) ? ST_OK : ST_ABSENT;
        OP_REMOVE: begin
          if (hit < NIL) begin
            if (prev < NIL) link_q[prev] = link_q[hit];
            else head_q[b] = link_q[hit];
            link_q[hit] = free_hd;
            free_hd = hit;
            if (len_q[b] > 0) len_q[b]--;
            if (total > 0) total--;
            r.status = ST_OK;
          end
        end
        default: ;
      endcase
      r.count  = total;
      r.length = len_q[b];
      awaited_q.push_back(r);
    endfunction

    function void check_result(status_e st, logic [CNT_W-1:0] cnt, logic [CNT_W-1:0] len);
      hash_result_t e;
      checked++;
      status_seen[st]++;
      if (awaited_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result status=%0d count=%0d length=%0d", st, cnt, len);
        return;
      end
      e = awaited_q.pop_front();
      if (e.status !== st || e.count !== cnt || e.length !== len) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d exp st=%0d cnt=%0d len=%0d got st=%0d cnt=%0d len=%0d",
                   checked, e.status, e.count, e.length, st, cnt, len);
      end
    endfunction
  endclass

  logic               clk_i, rst_ni;
  logic               cfg_we_i;
  logic [CFG_W-1:0]   cfg_wdata_i;
  logic               s_axis_tvalid, s_axis_tready;
  logic [31:0]        s_axis_tdata;
  logic [OP_W-1:0]    s_axis_tuser;
  logic               m_axis_tvalid, m_axis_tready;
  logic [23:0]        m_axis_tdata;
  logic [STATUS_W-1:0] m_axis_tuser;

  hash_set_scoreboard sb;
  bit    gaps_on;
  bit    hold_req;
  int    items_sent;
  logic [VALUE_W-1:0] keys[48];

  chained_hash_set u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #100ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: random back-pressure plus one long hold on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready = 1'b0;
        repeat (400) @(negedge clk_i);
      end
      m_axis_tready = !(gaps_on && $urandom_range(0, 99) < 8);
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(status_e'(m_axis_tuser), m_axis_tdata[10:0], m_axis_tdata[21:11]);

  task automatic send_item(op_e op, logic [VALUE_W-1:0] v);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(0, 99) < 8) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {1'b0, v};
    s_axis_tuser  = op;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(op, v);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.awaited_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_buckets(logic [CFG_W-1:0] n);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = n;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_buckets(n);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return keys[$urandom_range(0, 47)];
    if (r < 85) return VALUE_W'($urandom_range(0, 200));
    return VALUE_W'($urandom);
  endfunction

  function automatic op_e pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 42) return OP_INSERT;
    if (r < 68) return OP_SEARCH;
    if (r < 95) return OP_REMOVE;
    return OP_NONE;
  endfunction

  initial begin
    logic [CFG_W-1:0] plan[6];
    int fill;
    plan = '{7'd1, 7'd127, 7'd0, 7'd100, 7'd13, 7'd64};
    sb = new();
    gaps_on = 1'b1;
    hold_req = 1'b0;
    items_sent = 0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_INSERT;
    for (int i = 0; i < 48; i++) keys[i] = VALUE_W'($urandom);
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // wait out the clearing pass
    do @(posedge clk_i); while (!s_axis_tready);

    // directed: reset bucket count, extremes, chain ordering, corner ops
    send_item(OP_REMOVE, 31'd0);           // remove on empty chain
    send_item(OP_SEARCH, 31'd0);
    send_item(OP_INSERT, 31'd0);
    send_item(OP_INSERT, 31'h7FFF_FFFF);
    send_item(OP_INSERT, 31'd0);           // duplicate
    send_item(OP_INSERT, 31'd64);
    send_item(OP_INSERT, 31'd128);         // bucket 0 now three deep
    send_item(OP_SEARCH, 31'd64);
    send_item(OP_SEARCH, 31'd192);         // absent in a busy chain
    send_item(OP_REMOVE, 31'd192);
    send_item(OP_REMOVE, 31'd64);          // middle of the chain
    send_item(OP_SEARCH, 31'd0);
    send_item(OP_NONE,   31'd128);
    send_item(OP_REMOVE, 31'd128);         // head of the chain
    send_item(OP_INSERT, 31'd64);          // reuses a freed node
    send_item(OP_SEARCH, 31'h7FFF_FFFF);
    send_item(OP_REMOVE, 31'h7FFF_FFFF);
    send_item(OP_NONE,   31'h2AAA_AAAA);
    send_item(OP_INSERT, 31'h5555_5555);
    send_item(OP_INSERT, 31'h2AAA_AAAA);
    drain();

    // bucket count sweep; stored values stay put and are not rehashed
    for (int ph = 0; ph < 6; ph++) begin
      write_buckets(plan[ph]);
      for (int i = 0; i < 6; i++) begin
        gaps_on = !(ph == 3);
        send_item(pick_op(), pick_value());
      end
      drain();
    end
    gaps_on = 1'b1;

    // fill the pool at 64 buckets, with a long output stall on the way
    hold_req = 1'b1;
    fill = NP - int'(sb.total) + 8;
    for (int i = 0; i < fill; i++) begin
      gaps_on = !(i > 300 && i < 500);
      send_item(OP_INSERT, VALUE_W'($urandom));
    end
    gaps_on = 1'b1;
    for (int i = 0; i < 18; i++)
      send_item((i % 3 == 0) ? OP_REMOVE : pick_op(),
                (i % 3 == 0) ? keys[i % 48] : pick_value());
    drain();

    while (sb.awaited_q.size() != 0) @(posedge clk_i);
    $display("Covered %0d items, %0d results: %0d ok, %0d absent, %0d duplicate, %0d full",
             items_sent, sb.checked, sb.status_seen[0], sb.status_seen[1],
             sb.status_seen[2], sb.status_seen[3]);
    $display("Bucket counts swept 64,1,127,0,100,13,64; %0d mismatches", sb.mismatches);
    if (sb.mismatches == 0 && sb.awaited_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* chained_hash_set.f */
rtl/core/chs_pkg.sv
rtl/core/chs_mod_unit.sv
rtl/core/chained_hash_set.sv
verif/tb.sv
